[rtl/tsi_pkg.sv]
// tsi_pkg: types, codes and helper functions of the teleop setpoint integrator
// no dependencies; used by every other rtl file
`default_nettype none

package tsi_pkg;

    localparam logic [1:0] CMD_JOY      = 2'd0;
    localparam logic [1:0] CMD_ACTIVATE = 2'd1;
    localparam logic [1:0] CMD_STEP     = 2'd2;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_SCALE_FWD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POS_SCALE_LAT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POS_SCALE_VRT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_STEP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_SCALE_X   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_SCALE_Y   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_SCALE_Z   = 3'd7;

    localparam logic [15:0] GAIN_RESET     = 16'd6554;
    localparam logic [15:0] YAW_STEP_RESET = 16'd104;

    localparam longint SIN_A = 64'sd1686629713;
    localparam longint SIN_B = 64'sd688904866;
    localparam longint SIN_C = 64'sd76016977;

    typedef struct packed {
        logic [1:0]          cmd;
        logic signed [15:0]  axis_yaw;
        logic signed [15:0]  axis_thrust;
        logic signed [15:0]  axis_lateral;
        logic signed [15:0]  axis_forward;
        logic                disable_button;
        logic signed [31:0]  start_x;
        logic signed [31:0]  start_y;
        logic signed [31:0]  start_z;
        logic signed [15:0]  start_heading;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0]  set_x;
        logic signed [31:0]  set_y;
        logic signed [31:0]  set_z;
        logic signed [15:0]  set_heading;
        logic                is_velocity;
        logic                is_valid;
    } t_out_item;

    typedef struct packed {
        logic        velocity_mode;
        logic [15:0] pos_scale_forward;
        logic [15:0] pos_scale_lateral;
        logic [15:0] pos_scale_vertical;
        logic [15:0] yaw_step_scale;
        logic [15:0] vel_scale_x;
        logic [15:0] vel_scale_y;
        logic [15:0] vel_scale_z;
    } t_cfg;

    typedef enum logic [3:0] {
        MUL_YAW_STEP,
        MUL_YAW_RATE,
        MUL_VX,
        MUL_VY,
        MUL_VZ,
        MUL_DX,
        MUL_DY,
        MUL_DZ,
        MUL_DXC,
        MUL_DYS,
        MUL_DYC,
        MUL_DXS
    } t_mul_sel;

    typedef enum logic [3:0] {
        WB_NONE,
        WB_HEADING,
        WB_YAW_RATE,
        WB_VX,
        WB_VY,
        WB_VZ,
        WB_DX,
        WB_DY,
        WB_Z,
        WB_ACC_LOAD,
        WB_ACC_SUB,
        WB_X_ACC,
        WB_ACC_ADD,
        WB_Y
    } t_wb_sel;

    typedef struct packed {
        t_mul_sel mul_sel;
        t_wb_sel  wb_sel;
        logic     joy_load;
        logic     activate;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic joy_seen;
    } t_dp_stat;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_V0, ST_V1, ST_V2, ST_V3, ST_V4,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4,
        ST_P5, ST_P6, ST_P7, ST_P8, ST_P9,
        ST_OUT
    } t_state;

    function automatic longint quarter_sine(input longint z);
        longint z2;
        longint t;
        z2 = (z * z) >>> 30;
        t  = SIN_B - ((z2 * SIN_C) >>> 30);
        t  = SIN_A - ((z2 * t) >>> 30);
        return (z * t) >>> 30;
    endfunction

    // q15 sine table entry, full turn over 2^bits entries
    function automatic int trig_entry(input int idx, input int bits);
        longint qsize;
        longint quad;
        longint f;
        longint z;
        longint s;
        qsize = 64'sd1 << (bits - 2);
        quad  = (longint'(idx) >>> (bits - 2)) & 64'sd3;
        f     = longint'(idx) & (qsize - 64'sd1);
        z     = f << (30 - (bits - 2));
        if (quad[0])
            z = (64'sd1 <<< 30) - z;
        s = (quarter_sine(z) + 64'sd16384) >>> 15;
        return quad[1] ? int'(-s) : int'(s);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
        if (v > 21'sd32767)
            return 16'sh7fff;
        else if (v < -21'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                     input logic signed [21:0] d);
        logic signed [32:0] sum;
        sum = {a[31], a} + {{11{d[21]}}, d};
        if (sum[32] != sum[31])
            return sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            return sum[31:0];
    endfunction

endpackage

`default_nettype wire

[rtl/tsi_if.sv]
// tsi_if: valid/ready channel interfaces for items, results and register writes
// depends on tsi_pkg for the payload types
`default_nettype none

interface tsi_item_if;
    logic                valid;
    logic                ready;
    tsi_pkg::t_in_item   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tsi_result_if;
    logic                valid;
    logic                ready;
    tsi_pkg::t_out_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tsi_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tsi_pkg::CFG_IDX_W-1:0]      index;
    logic [15:0]                        data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/tsi_cfg.sv]
// tsi_cfg: configuration register file, one write beat per cycle
// depends on tsi_pkg and tsi_if
`default_nettype none

module tsi_cfg (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tsi_cfg_if.sink     i_cfg,
    output tsi_pkg::t_cfg o_cfg
);
    import tsi_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.velocity_mode      <= 1'b0;
            r_cfg.pos_scale_forward  <= GAIN_RESET;
            r_cfg.pos_scale_lateral  <= GAIN_RESET;
            r_cfg.pos_scale_vertical <= GAIN_RESET;
            r_cfg.yaw_step_scale     <= YAW_STEP_RESET;
            r_cfg.vel_scale_x        <= GAIN_RESET;
            r_cfg.vel_scale_y        <= GAIN_RESET;
            r_cfg.vel_scale_z        <= GAIN_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_VELOCITY_MODE: r_cfg.velocity_mode      <= i_cfg.data[0];
                REG_POS_SCALE_FWD: r_cfg.pos_scale_forward  <= i_cfg.data;
                REG_POS_SCALE_LAT: r_cfg.pos_scale_lateral  <= i_cfg.data;
                REG_POS_SCALE_VRT: r_cfg.pos_scale_vertical <= i_cfg.data;
                REG_YAW_STEP:      r_cfg.yaw_step_scale     <= i_cfg.data;
                REG_VEL_SCALE_X:   r_cfg.vel_scale_x        <= i_cfg.data;
                REG_VEL_SCALE_Y:   r_cfg.vel_scale_y        <= i_cfg.data;
                REG_VEL_SCALE_Z:   r_cfg.vel_scale_z        <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/tsi_ctrl.sv]
// tsi_ctrl: sequencer for the shared multiplier and the result register handshake
// depends on tsi_pkg
`default_nettype none

module tsi_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic [1:0]  i_in_cmd,
    output logic             o_in_ready,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    input  wire logic        i_velocity_mode,
    input  wire tsi_pkg::t_dp_stat i_stat,
    output tsi_pkg::t_dp_cmd  o_cmd
);
    import tsi_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.mul_sel = MUL_YAW_STEP;
        o_cmd.wb_sel  = WB_NONE;
        o_cmd.joy_load = 1'b0;
        o_cmd.activate = 1'b0;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    priority if (i_in_cmd == CMD_JOY) begin
                        o_cmd.joy_load = 1'b1;
                    end else if (i_in_cmd == CMD_ACTIVATE) begin
                        o_cmd.activate = 1'b1;
                    end else if (i_in_cmd == CMD_STEP) begin
                        priority if (!i_stat.joy_seen) n_state = ST_OUT;
                        else if (i_velocity_mode)       n_state = ST_V0;
                        else                            n_state = ST_P0;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_V0: begin
                o_cmd.mul_sel = MUL_YAW_RATE;
                n_state = ST_V1;
            end
            ST_V1: begin
                o_cmd.mul_sel = MUL_VX;
                o_cmd.wb_sel  = WB_YAW_RATE;
                n_state = ST_V2;
            end
            ST_V2: begin
                o_cmd.mul_sel = MUL_VY;
                o_cmd.wb_sel  = WB_VX;
                n_state = ST_V3;
            end
            ST_V3: begin
                o_cmd.mul_sel = MUL_VZ;
                o_cmd.wb_sel  = WB_VY;
                n_state = ST_V4;
            end
            ST_V4: begin
                o_cmd.wb_sel = WB_VZ;
                n_state = ST_OUT;
            end
            ST_P0: begin
                o_cmd.mul_sel = MUL_YAW_STEP;
                n_state = ST_P1;
            end
            ST_P1: begin
                o_cmd.mul_sel = MUL_DX;
                o_cmd.wb_sel  = WB_HEADING;
                n_state = ST_P2;
            end
            ST_P2: begin
                o_cmd.mul_sel = MUL_DY;
                o_cmd.wb_sel  = WB_DX;
                n_state = ST_P3;
            end
            ST_P3: begin
                o_cmd.mul_sel = MUL_DZ;
                o_cmd.wb_sel  = WB_DY;
                n_state = ST_P4;
            end
            ST_P4: begin
                o_cmd.mul_sel = MUL_DXC;
                o_cmd.wb_sel  = WB_Z;
                n_state = ST_P5;
            end
            ST_P5: begin
                o_cmd.mul_sel = MUL_DYS;
                o_cmd.wb_sel  = WB_ACC_LOAD;
                n_state = ST_P6;
            end
            ST_P6: begin
                o_cmd.mul_sel = MUL_DYC;
                o_cmd.wb_sel  = WB_ACC_SUB;
                n_state = ST_P7;
            end
            ST_P7: begin
                o_cmd.mul_sel = MUL_DXS;
                o_cmd.wb_sel  = WB_X_ACC;
                n_state = ST_P8;
            end
            ST_P8: begin
                o_cmd.wb_sel = WB_ACC_ADD;
                n_state = ST_P9;
            end
            ST_P9: begin
                o_cmd.wb_sel = WB_Y;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        priority if (o_cmd.out_load) n_out_valid = 1'b1;
        else if (i_out_ready)        n_out_valid = 1'b0;
    end

    a_skip_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_cmd == CMD_STEP && !i_stat.joy_seen) |=> r_state == ST_OUT)
        else $error("step without joystick data did not go straight to output");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while still held");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid)
        else $error("loaded result not presented");

    a_pos_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_P9) |=> (r_state == ST_OUT))
        else $error("position sequence did not end at output");

endmodule

`default_nettype wire

[rtl/tsi_dp.sv]
// tsi_dp: state registers, shared 18x18 multiplier, sine table and result register
// depends on tsi_pkg
`default_nettype none

module tsi_dp #(
    parameter int YAW_RATE_SCALE  = 104,
    parameter int TRIG_TABLE_BITS = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tsi_pkg::t_in_item i_item,
    input  wire tsi_pkg::t_cfg     i_cfg,
    input  wire tsi_pkg::t_dp_cmd  i_cmd,
    output tsi_pkg::t_dp_stat  o_stat,
    output tsi_pkg::t_out_item o_data
);
    import tsi_pkg::*;

    localparam int TBL_SIZE = 1 << TRIG_TABLE_BITS;
    localparam logic [TRIG_TABLE_BITS-1:0] QTR = TRIG_TABLE_BITS'(TBL_SIZE / 4);

    logic signed [15:0] r_yaw, r_thr, r_lat, r_fwd;
    logic               r_joy_seen;
    logic               r_valid;
    logic signed [31:0] r_pos [3];
    logic        [15:0] r_heading;
    logic signed [31:0] r_vel [3];
    logic signed [15:0] r_yaw_rate;

    logic signed [35:0] r_prod;
    logic signed [36:0] r_acc;
    logic signed [17:0] r_dx, r_dy;
    logic signed [16:0] r_sin, r_cos;
    t_out_item          r_out;

    logic signed [16:0] w_tab [TBL_SIZE];
    logic [TRIG_TABLE_BITS-1:0] w_addr;
    logic signed [16:0] w_neg_yaw, w_neg_lat, w_neg_thr;
    logic signed [17:0] w_a, w_b;
    logic signed [20:0] w_sh;

    for (genvar g = 0; g < TBL_SIZE; g++) begin : g_tab
        localparam int ENTRY = trig_entry(g, TRIG_TABLE_BITS);
        assign w_tab[g] = 17'(ENTRY);
    end

    assign w_addr    = r_heading[15 -: TRIG_TABLE_BITS];
    assign w_neg_yaw = -{r_yaw[15], r_yaw};
    assign w_neg_lat = -{r_lat[15], r_lat};
    assign w_neg_thr = -{r_thr[15], r_thr};
    assign w_sh      = r_prod[35:15];

    assign o_stat.joy_seen = r_joy_seen;
    assign o_data          = r_out;

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_YAW_STEP: begin
                w_a = {w_neg_yaw[16], w_neg_yaw};
                w_b = {2'b00, i_cfg.yaw_step_scale};
            end
            MUL_YAW_RATE: begin
                w_a = {w_neg_yaw[16], w_neg_yaw};
                w_b = {2'b00, 16'(YAW_RATE_SCALE)};
            end
            MUL_VX: begin
                w_a = {{2{r_fwd[15]}}, r_fwd};
                w_b = {2'b00, i_cfg.vel_scale_x};
            end
            MUL_VY: begin
                w_a = {w_neg_lat[16], w_neg_lat};
                w_b = {2'b00, i_cfg.vel_scale_y};
            end
            MUL_VZ: begin
                w_a = {w_neg_thr[16], w_neg_thr};
                w_b = {2'b00, i_cfg.vel_scale_z};
            end
            MUL_DX: begin
                w_a = {{2{r_fwd[15]}}, r_fwd};
                w_b = {2'b00, i_cfg.pos_scale_forward};
            end
            MUL_DY: begin
                w_a = {w_neg_lat[16], w_neg_lat};
                w_b = {2'b00, i_cfg.pos_scale_lateral};
            end
            MUL_DZ: begin
                w_a = {w_neg_thr[16], w_neg_thr};
                w_b = {2'b00, i_cfg.pos_scale_vertical};
            end
            MUL_DXC: begin
                w_a = r_dx;
                w_b = {r_cos[16], r_cos};
            end
            MUL_DYS: begin
                w_a = r_dy;
                w_b = {r_sin[16], r_sin};
            end
            MUL_DYC: begin
                w_a = r_dy;
                w_b = {r_cos[16], r_cos};
            end
            MUL_DXS: begin
                w_a = r_dx;
                w_b = {r_sin[16], r_sin};
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    // product, trig lookup and rotation scratch
    always_ff @(posedge i_clk) begin
        r_prod <= w_a * w_b;
        r_sin  <= w_tab[w_addr];
        r_cos  <= w_tab[w_addr + QTR];
        unique case (i_cmd.wb_sel)
            WB_DX:       r_dx  <= w_sh[17:0];
            WB_DY:       r_dy  <= w_sh[17:0];
            WB_ACC_LOAD: r_acc <= {r_prod[35], r_prod};
            WB_ACC_SUB:  r_acc <= r_acc - {r_prod[35], r_prod};
            WB_X_ACC:    r_acc <= {r_prod[35], r_prod};
            WB_ACC_ADD:  r_acc <= r_acc + {r_prod[35], r_prod};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw      <= '0;
            r_thr      <= '0;
            r_lat      <= '0;
            r_fwd      <= '0;
            r_joy_seen <= 1'b0;
            r_valid    <= 1'b0;
            r_pos[0]   <= '0;
            r_pos[1]   <= '0;
            r_pos[2]   <= '0;
            r_heading  <= '0;
            r_vel[0]   <= '0;
            r_vel[1]   <= '0;
            r_vel[2]   <= '0;
            r_yaw_rate <= '0;
        end else begin
            if (i_cmd.joy_load) begin
                r_yaw      <= i_item.axis_yaw;
                r_thr      <= i_item.axis_thrust;
                r_lat      <= i_item.axis_lateral;
                r_fwd      <= i_item.axis_forward;
                r_joy_seen <= 1'b1;
                if (i_item.disable_button)
                    r_valid <= 1'b0;
            end
            if (i_cmd.activate) begin
                r_pos[0]  <= i_item.start_x;
                r_pos[1]  <= i_item.start_y;
                r_pos[2]  <= i_item.start_z;
                r_heading <= i_item.start_heading;
                r_valid   <= 1'b1;
            end
            unique case (i_cmd.wb_sel)
                WB_HEADING:  r_heading  <= r_heading + w_sh[15:0];
                WB_YAW_RATE: r_yaw_rate <= sat16(w_sh);
                WB_VX:       r_vel[0]   <= {{11{w_sh[20]}}, w_sh};
                WB_VY:       r_vel[1]   <= {{11{w_sh[20]}}, w_sh};
                WB_VZ:       r_vel[2]   <= {{11{w_sh[20]}}, w_sh};
                WB_Z:        r_pos[2]   <= sat_add32(r_pos[2], {w_sh[20], w_sh});
                WB_X_ACC:    r_pos[0]   <= sat_add32(r_pos[0], r_acc[36:15]);
                WB_Y:        r_pos[1]   <= sat_add32(r_pos[1], r_acc[36:15]);
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.is_velocity <= i_cfg.velocity_mode;
            r_out.is_valid    <= r_valid;
            if (i_cfg.velocity_mode) begin
                r_out.set_x       <= r_vel[0];
                r_out.set_y       <= r_vel[1];
                r_out.set_z       <= r_vel[2];
                r_out.set_heading <= r_yaw_rate;
            end else begin
                r_out.set_x       <= r_pos[0];
                r_out.set_y       <= r_pos[1];
                r_out.set_z       <= r_pos[2];
                r_out.set_heading <= r_heading;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/teleop_setpoint_integrator_top.sv]
// teleop_setpoint_integrator_top: joystick axes to position or velocity setpoints
// depends on tsi_pkg, tsi_if, tsi_cfg, tsi_ctrl and tsi_dp
//
//  channel    dir  beat carries
//  i_item     in   cmd, four stick axes, disable button, start pose
//  o_result   out  set_x/y/z, set_heading, is_velocity, is_valid (step only)
//  i_cfg      in   register index 0..7, 16-bit write data
//
// items are accepted only in idle; joystick update and activate stay in idle
// a step runs V0..V4 (velocity mode) or P0..P9 (position mode), paced by the
// single shared 18x18 multiplier, then ST_OUT waits for a free result register
// a step before any joystick update goes from idle straight to ST_OUT
// synchronous active-low reset clears setpoint state and loads register defaults
// the result register holds a finished beat while the next item is accepted
`default_nettype none

module teleop_setpoint_integrator_top #(
    parameter int YAW_RATE_SCALE  = 104,
    parameter int TRIG_TABLE_BITS = 10
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    tsi_item_if.sink       i_item,
    tsi_result_if.source   o_result,
    tsi_cfg_if.sink        i_cfg
);
    import tsi_pkg::*;

    t_cfg      w_cfg;
    t_dp_cmd   w_cmd;
    t_dp_stat  w_stat;
    t_out_item w_out;
    logic      w_in_ready;
    logic      w_out_valid;

    assign i_item.ready   = w_in_ready;
    assign o_result.valid = w_out_valid;
    assign o_result.data  = w_out;

    tsi_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    tsi_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_item.valid),
        .i_in_cmd        (i_item.data.cmd),
        .o_in_ready      (w_in_ready),
        .i_out_ready     (o_result.ready),
        .o_out_valid     (w_out_valid),
        .i_velocity_mode (w_cfg.velocity_mode),
        .i_stat          (w_stat),
        .o_cmd           (w_cmd)
    );

    tsi_dp #(
        .YAW_RATE_SCALE  (YAW_RATE_SCALE),
        .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item.data),
        .i_cfg   (w_cfg),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_data  (w_out)
    );

endmodule

`default_nettype wire

[tb/teleop_setpoint_integrator_top_tb.sv]
`timescale 1ns / 1ps
// teleop_setpoint_integrator_top_tb: self-checking bench for the setpoint integrator
// a directed table then random command sequences, checked against an in-bench predictor
// depends on tsi_pkg, tsi_if and the teleop_setpoint_integrator_top rtl

module teleop_setpoint_integrator_top_tb;

    import tsi_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int YAW_RATE_K    = 104;
    localparam int TRIG_BITS     = 10;
    localparam int QUARTER       = 1 << (TRIG_BITS - 2);
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 155;
    localparam int CYCLE_LIMIT   = 400000;

    localparam longint POLY_A = 64'sd1686629713;
    localparam longint POLY_B = 64'sd688904866;
    localparam longint POLY_C = 64'sd76016977;

    localparam logic [15:0] GAIN_DEFAULT     = 16'd6554;
    localparam logic [15:0] YAW_STEP_DEFAULT = 16'd104;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum bit {ROW_WRITE, ROW_BEAT} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [15:0]            reg_val;
        t_in_item               beat;
        bit                     typed;
        t_out_item              want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tsi_item_if   item_ch ();
    tsi_result_if res_ch ();
    tsi_cfg_if    cfg_ch ();

    teleop_setpoint_integrator_top #(
        .YAW_RATE_SCALE  (YAW_RATE_K),
        .TRIG_TABLE_BITS (TRIG_BITS)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predictor state
    t_cfg               gains_now = '{1'b0, GAIN_DEFAULT, GAIN_DEFAULT, GAIN_DEFAULT,
                                      YAW_STEP_DEFAULT, GAIN_DEFAULT, GAIN_DEFAULT,
                                      GAIN_DEFAULT};
    logic signed [15:0] stick_yaw = '0;
    logic signed [15:0] stick_thr = '0;
    logic signed [15:0] stick_lat = '0;
    logic signed [15:0] stick_fwd = '0;
    bit                 sticks_seen = 1'b0;
    bit                 armed = 1'b0;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_y = '0;
    logic signed [31:0] pos_z = '0;
    logic [15:0]        heading = '0;
    logic signed [31:0] vel_x = '0;
    logic signed [31:0] vel_y = '0;
    logic signed [31:0] vel_z = '0;
    logic signed [15:0] yaw_rate = '0;

    t_out_item setpoint_q[$];
    t_dir_row  dir_rows[$];
    int        mismatches = 0;
    int        cycle_count = 0;
    bit        steady_tail = 1'b0;
    int        feed_gap_pct = 20;
    int        sink_stall_pct = 20;

    function automatic longint stick_scale(input longint a, input logic [15:0] g);
        return (a * longint'({48'd0, g})) >>> 15;
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 64'sd32767)
            return 16'sh7fff;
        if (v < -64'sd32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // q15 sine over a full turn of 2^TRIG_BITS steps, odd polynomial per quadrant
    function automatic longint sine_q15(input int a);
        longint     z;
        longint     zz;
        longint     acc;
        logic [1:0] quad;
        quad = 2'((a >> (TRIG_BITS - 2)) & 3);
        z = longint'(a & (QUARTER - 1)) << (30 - (TRIG_BITS - 2));
        if (quad[0])
            z = (64'sd1 <<< 30) - z;
        zz  = (z * z) >>> 30;
        acc = POLY_B - ((zz * POLY_C) >>> 30);
        acc = POLY_A - ((zz * acc) >>> 30);
        acc = (z * acc) >>> 30;
        acc = (acc + 64'sd16384) >>> 15;
        return quad[1] ? -acc : acc;
    endfunction

    task automatic advance_setpoint(input t_in_item it, output bit has, output t_out_item res);
        longint                 dyaw;
        longint                 dx;
        longint                 dy;
        longint                 dz;
        longint                 sn;
        longint                 cs;
        logic [TRIG_BITS-1:0]   addr;
        logic [TRIG_BITS-1:0]   caddr;
        has = 1'b0;
        res = '0;
        case (it.cmd)
            CMD_JOY: begin
                stick_yaw = it.axis_yaw;
                stick_thr = it.axis_thrust;
                stick_lat = it.axis_lateral;
                stick_fwd = it.axis_forward;
                sticks_seen = 1'b1;
                if (it.disable_button)
                    armed = 1'b0;
            end
            CMD_ACTIVATE: begin
                pos_x = it.start_x;
                pos_y = it.start_y;
                pos_z = it.start_z;
                heading = it.start_heading;
                armed = 1'b1;
            end
            CMD_STEP: begin
                has = 1'b1;
                if (gains_now.velocity_mode) begin
                    if (sticks_seen) begin
                        yaw_rate = clamp16(stick_scale(-longint'(stick_yaw), 16'(YAW_RATE_K)));
                        vel_x = 32'(stick_scale(longint'(stick_fwd), gains_now.vel_scale_x));
                        vel_y = 32'(stick_scale(-longint'(stick_lat), gains_now.vel_scale_y));
                        vel_z = 32'(stick_scale(-longint'(stick_thr), gains_now.vel_scale_z));
                    end
                    res.set_x = vel_x;
                    res.set_y = vel_y;
                    res.set_z = vel_z;
                    res.set_heading = yaw_rate;
                    res.is_velocity = 1'b1;
                end else begin
                    if (sticks_seen) begin
                        dyaw = stick_scale(-longint'(stick_yaw), gains_now.yaw_step_scale);
                        heading = heading + dyaw[15:0];
                        addr  = heading[15 -: TRIG_BITS];
                        caddr = addr + TRIG_BITS'(QUARTER);
                        sn = sine_q15(int'(addr));
                        cs = sine_q15(int'(caddr));
                        dx = stick_scale(longint'(stick_fwd), gains_now.pos_scale_forward);
                        dy = stick_scale(-longint'(stick_lat), gains_now.pos_scale_lateral);
                        dz = stick_scale(-longint'(stick_thr), gains_now.pos_scale_vertical);
                        pos_x = clamp32(longint'(pos_x) + ((dx * cs - dy * sn) >>> 15));
                        pos_y = clamp32(longint'(pos_y) + ((dy * cs + dx * sn) >>> 15));
                        pos_z = clamp32(longint'(pos_z) + dz);
                    end
                    res.set_x = pos_x;
                    res.set_y = pos_y;
                    res.set_z = pos_z;
                    res.set_heading = heading;
                    res.is_velocity = 1'b0;
                end
                res.is_valid = armed;
            end
            default: ;
        endcase
    endtask

    function automatic t_in_item beat_of(input logic [1:0] cmd,
                                         input logic signed [15:0] yaw, thr, lat, fwd,
                                         input logic dis,
                                         input logic signed [31:0] sx, sy, sz,
                                         input logic signed [15:0] sh);
        t_in_item b;
        b.cmd = cmd;
        b.axis_yaw = yaw;
        b.axis_thrust = thr;
        b.axis_lateral = lat;
        b.axis_forward = fwd;
        b.disable_button = dis;
        b.start_x = sx;
        b.start_y = sy;
        b.start_z = sz;
        b.start_heading = sh;
        return b;
    endfunction

    function automatic t_out_item sp(input logic signed [31:0] x, y, z,
                                     input logic [15:0] h, input logic vel, ok);
        t_out_item r;
        r.set_x = x;
        r.set_y = y;
        r.set_z = z;
        r.set_heading = h;
        r.is_velocity = vel;
        r.is_valid = ok;
        return r;
    endfunction

    function automatic t_dir_row row_beat(input t_in_item b, input bit typed,
                                          input t_out_item want);
        t_dir_row r;
        r.kind = ROW_BEAT;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.beat = b;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic t_dir_row row_write(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [15:0] val);
        t_dir_row r;
        r.kind = ROW_WRITE;
        r.reg_idx = idx;
        r.reg_val = val;
        r.beat = '0;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(0, 4))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return $urandom_range(0, 1) ? 16'shffff : 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return 32'($urandom);
            1: return 32'sh7fff_ffff - 32'($urandom_range(0, 1 << 20));
            2: return 32'sh8000_0000 + 32'($urandom_range(0, 1 << 20));
            default: return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
        endcase
    endfunction

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int rand_pace();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 8;
            2: return 25;
            default: return 50;
        endcase
    endfunction

    function automatic t_in_item noise_beat();
        t_in_item b;
        b.cmd = 2'($urandom);
        b.axis_yaw = 16'($urandom);
        b.axis_thrust = 16'($urandom);
        b.axis_lateral = 16'($urandom);
        b.axis_forward = 16'($urandom);
        b.disable_button = 1'($urandom);
        b.start_x = 32'($urandom);
        b.start_y = 32'($urandom);
        b.start_z = 32'($urandom);
        b.start_heading = 16'($urandom);
        return b;
    endfunction

    task automatic send_beat(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item pred;
        bit        has;
        if (!steady_tail && $urandom_range(0, 99) < feed_gap_pct) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        do @(posedge i_clk); while (!item_ch.ready);
        advance_setpoint(it, has, pred);
        if (has)
            setpoint_q.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    task automatic drain_setpoints();
        item_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (setpoint_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic settle_idle();
        drain_setpoints();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_VELOCITY_MODE: gains_now.velocity_mode = val[0];
            REG_POS_SCALE_FWD: gains_now.pos_scale_forward = val;
            REG_POS_SCALE_LAT: gains_now.pos_scale_lateral = val;
            REG_POS_SCALE_VRT: gains_now.pos_scale_vertical = val;
            REG_YAW_STEP:      gains_now.yaw_step_scale = val;
            REG_VEL_SCALE_X:   gains_now.vel_scale_x = val;
            REG_VEL_SCALE_Y:   gains_now.vel_scale_y = val;
            REG_VEL_SCALE_Z:   gains_now.vel_scale_z = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        t_out_item got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.data;
            if (setpoint_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat with nothing expected: x %0d y %0d z %0d h %0d",
                             got.set_x, got.set_y, got.set_z, got.set_heading);
            end else begin
                want = setpoint_q.pop_front();
                check_field("set_x", want.set_x, got.set_x);
                check_field("set_y", want.set_y, got.set_y);
                check_field("set_z", want.set_z, got.set_z);
                check_field("set_heading", want.set_heading, got.set_heading);
                check_field("is_velocity", want.is_velocity, got.is_velocity);
                check_field("is_valid", want.is_valid, got.is_valid);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("teleop_setpoint_integrator_top_tb NOT OK");
            $finish;
        end
    end

    // result side back-pressure
    initial begin : sink_pacing
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!steady_tail && $urandom_range(0, 99) < sink_stall_pct) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        t_in_item    beat;
        logic [15:0] reg_vals [8];
        int          ph;
        int          r;
        int          done_items;
        int          pause_at;
        int          pick;
        bit          paused;

        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;

        // velocity and position steps before any stick input
        dir_rows.push_back(row_write(REG_VELOCITY_MODE, 16'd1));
        dir_rows.push_back(row_beat(beat_of(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                    1'b1, sp(0, 0, 0, 16'h0000, 1'b1, 1'b0)));
        dir_rows.push_back(row_write(REG_VELOCITY_MODE, 16'd0));
        dir_rows.push_back(row_beat(beat_of(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                    1'b1, sp(0, 0, 0, 16'h0000, 1'b0, 1'b0)));
        dir_rows.push_back(row_beat(beat_of(CMD_UNUSED, 16'shffff, 16'shffff, 16'shffff,
                                            16'shffff, 1'b1, 32'shffff_ffff,
                                            32'shffff_ffff, 32'shffff_ffff, 16'shffff),
                                    1'b0, '0));
        // activate at the pose extremes, step with no sticks returns the start pose
        dir_rows.push_back(row_beat(beat_of(CMD_ACTIVATE, 0, 0, 0, 0, 0, 32'sh7fff_ffff,
                                            32'sh8000_0000, 32'sh0001_0000, 16'sh8000),
                                    1'b0, '0));
        dir_rows.push_back(row_beat(beat_of(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                                    sp(32'sh7fff_ffff, 32'sh8000_0000, 32'sh0001_0000,
                                       16'h8000, 1'b0, 1'b1)));
        dir_rows.push_back(row_beat(beat_of(CMD_JOY, 16'sh8000, 16'sh7fff, 16'sh8000,
                                            16'sh7fff, 1'b0, 0, 0, 0, 0), 1'b0, '0));
        dir_rows.push_back(row_beat(beat_of(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0));
        dir_rows.push_back(row_beat(beat_of(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0));
        // positive yaw from heading zero must wrap below zero
        dir_rows.push_back(row_beat(beat_of(CMD_JOY, 16'sh7fff, 16'sh8000, 16'sh7fff,
                                            16'sh8000, 1'b0, 0, 0, 0, 0), 1'b0, '0));
        dir_rows.push_back(row_beat(beat_of(CMD_ACTIVATE, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                    1'b0, '0));
        dir_rows.push_back(row_beat(beat_of(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0));
        dir_rows.push_back(row_beat(beat_of(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0));
        // disable pressed, then released: valid stays cleared
        dir_rows.push_back(row_beat(beat_of(CMD_JOY, 16'sh4000, 16'sh1234, 16'shc000,
                                            16'sh2000, 1'b1, 0, 0, 0, 0), 1'b0, '0));
        dir_rows.push_back(row_beat(beat_of(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0));
        dir_rows.push_back(row_beat(beat_of(CMD_JOY, 16'shc000, 16'sh0100, 16'sh0200,
                                            16'sh0300, 1'b0, 0, 0, 0, 0), 1'b0, '0));
        dir_rows.push_back(row_beat(beat_of(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0));
        dir_rows.push_back(row_beat(beat_of(CMD_ACTIVATE, 0, 0, 0, 0, 0, 32'sh8000_0005,
                                            32'sh7fff_fffc, 32'sh8000_0000, 16'sh7fff),
                                    1'b0, '0));
        dir_rows.push_back(row_beat(beat_of(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0));
        // velocity mode, holds kept across activate
        dir_rows.push_back(row_write(REG_VELOCITY_MODE, 16'd1));
        dir_rows.push_back(row_beat(beat_of(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0));
        dir_rows.push_back(row_beat(beat_of(CMD_ACTIVATE, 0, 0, 0, 0, 0, 32'sh0000_1000,
                                            32'sh0000_2000, 32'sh0000_3000, 16'sh0400),
                                    1'b0, '0));
        dir_rows.push_back(row_beat(beat_of(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0));
        dir_rows.push_back(row_beat(beat_of(CMD_JOY, 16'sh8000, 16'sh8000, 16'sh8000,
                                            16'sh8000, 1'b0, 0, 0, 0, 0), 1'b0, '0));
        dir_rows.push_back(row_beat(beat_of(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n]) begin
            if (dir_rows[n].kind == ROW_WRITE) begin
                settle_idle();
                program_reg(dir_rows[n].reg_idx, dir_rows[n].reg_val);
                cfg_ch.valid <= 1'b0;
            end else begin
                send_beat(dir_rows[n].beat, dir_rows[n].typed, dir_rows[n].want);
            end
        end

        for (ph = 0; ph < PHASES; ph++) begin
            settle_idle();
            steady_tail = (ph == PHASES - 1);
            feed_gap_pct = rand_pace();
            sink_stall_pct = rand_pace();
            for (r = 0; r < 8; r++) begin
                case (ph)
                    0, 3:    reg_vals[r] = 16'h0000;
                    1, 2:    reg_vals[r] = 16'hffff;
                    default: reg_vals[r] = rand_gain();
                endcase
            end
            case (ph)
                0, 2:    reg_vals[REG_VELOCITY_MODE] = 16'd0;
                1, 3:    reg_vals[REG_VELOCITY_MODE] = 16'd1;
                default: reg_vals[REG_VELOCITY_MODE] = 16'($urandom_range(0, 1));
            endcase
            for (r = 0; r < 8; r++)
                program_reg(CFG_IDX_W'(r), reg_vals[r]);
            cfg_ch.valid <= 1'b0;

            done_items = 0;
            paused = 1'b0;
            pause_at = $urandom_range(20, PHASE_ITEMS - 20);
            while (done_items < PHASE_ITEMS) begin
                beat = noise_beat();
                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    beat.cmd = CMD_UNUSED;
                    send_beat(beat, 1'b0, '0);
                end else if (pick < 14) begin
                    beat.cmd = CMD_ACTIVATE;
                    beat.start_x = rand_pos();
                    beat.start_y = rand_pos();
                    beat.start_z = rand_pos();
                    send_beat(beat, 1'b0, '0);
                    done_items++;
                end else begin
                    beat.cmd = CMD_JOY;
                    beat.axis_yaw = rand_axis();
                    beat.axis_thrust = rand_axis();
                    beat.axis_lateral = rand_axis();
                    beat.axis_forward = rand_axis();
                    beat.disable_button = ($urandom_range(0, 11) == 0);
                    send_beat(beat, 1'b0, '0);
                    done_items++;
                    repeat ($urandom_range(1, 6)) begin
                        beat = noise_beat();
                        beat.cmd = CMD_STEP;
                        send_beat(beat, 1'b0, '0);
                        done_items++;
                    end
                end
                if (!paused && done_items >= pause_at) begin
                    drain_setpoints();
                    paused = 1'b1;
                end
            end
        end

        settle_idle();
        if (mismatches == 0 && setpoint_q.size() == 0)
            $display("teleop_setpoint_integrator_top_tb OK");
        else
            $display("teleop_setpoint_integrator_top_tb NOT OK");
        $finish;
    end

endmodule

[filelist.f]
rtl/tsi_pkg.sv
rtl/tsi_if.sv
rtl/tsi_cfg.sv
rtl/tsi_ctrl.sv
rtl/tsi_dp.sv
rtl/teleop_setpoint_integrator_top.sv
tb/teleop_setpoint_integrator_top_tb.sv
